FILE: rtl/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg: shared definitions for the trial division prime test
// Holds the candidate word width, the default datapath width and the status
// word that the shared divider reports to the sequencer.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // Width of the candidate word on the input port.
  localparam int CAND_W = 32;

  // Default value of the WIDTH parameter of the top level.
  localparam int WIDTH_DEFAULT = 32;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;  // a division is in progress
    logic done;  // quotient and remainder are valid in this cycle
  } tdp_div_status_t;

endpackage

FILE: rtl/tdp_divider.sv
// ----------------------------------------------------------------------------
// tdp_divider: shared restoring divider
// Divides an NW-bit dividend by an NW-bit divisor, one quotient bit per cycle.
// done is raised for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module tdp_divider #(
  parameter int NW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             dividend,
  input  logic [NW-1:0]             divisor,
  output tdp_pkg::tdp_div_status_t  status,
  output logic [NW-1:0]             quotient,
  output logic [NW-1:0]             remainder
);
  import tdp_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NW);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;

  logic [NW-1:0]    quo_r, quo_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r;

  logic [NW:0] trial;
  logic [NW:0] diff;
  logic        fits;

  // The quotient register first holds the dividend; its top bit moves into
  // the partial remainder while the new quotient bit enters at the bottom.
  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = ~diff[NW];

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_LOAD;
    end else if (cnt_r != CNT_ZERO) begin
      quo_nxt = {quo_r[NW-2:0], fits};
      rem_nxt = fits ? diff[NW-1:0] : trial[NW-1:0];
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CNT_ZERO;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= (cnt_r == CNT_ONE) && !start;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign status.busy = (cnt_r != CNT_ZERO);
  assign status.done = done_r;
  assign quotient    = quo_r;
  assign remainder   = rem_r;

endmodule

FILE: rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Pulse start with a candidate word while busy is low. For an odd candidate
// above one, busy rises in the next cycle and stays high until the answer is
// given. The answer appears on out_is_prime for exactly one cycle, marked by
// out_valid, and the receiver cannot stall it. Only the low WIDTH bits of the
// candidate are used (all 32 bits when WIDTH is 32 or more). Even candidates,
// 2 included, as well as 0 and 1, are answered as not prime in the cycle
// after they are taken, without any division, and busy stays low for them. An
// odd candidate n is divided by 3, 5, 7 and so on while the divisor does not
// exceed the quotient, which covers every divisor up to and including the
// integer square root. Each trial divisor runs on the single shared restoring
// divider, which is NW bits wide, where NW is the datapath width. An odd
// composite is answered after its smallest odd factor has been tried.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int WIDTH = tdp_pkg::WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [tdp_pkg::CAND_W-1:0] in_candidate,
  output logic                      out_valid,
  output logic                      out_is_prime
);
  import tdp_pkg::*;

  // The datapath is as wide as the usable part of the candidate word.
  localparam int NW = (WIDTH < CAND_W) ? WIDTH : CAND_W;

  localparam logic [NW-1:0] DIV_FIRST = NW'(3);
  localparam logic [NW-1:0] DIV_STEP  = NW'(2);
  localparam logic [NW-1:0] VAL_ONE   = NW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] cand_r, cand_nxt;
  logic [NW-1:0] dsr_r, dsr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_prime_r, out_prime_nxt;

  logic [NW-1:0]   cand_in;
  logic            div_start;
  tdp_div_status_t div_status;
  logic [NW-1:0]   div_quo;
  logic [NW-1:0]   div_rem;

  assign cand_in   = in_candidate[NW-1:0];
  assign div_start = (state_r == S_LAUNCH);

  // The shared divider computes cand / dsr for every trial divisor in turn.
  tdp_divider #(
    .NW (NW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (cand_r),
    .divisor   (dsr_r),
    .status    (div_status),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer. A new word is taken only in the idle state. Candidates that
  // are even or equal to one are answered at once. For odd candidates the
  // loop condition is checked before the remainder, exactly as in the usual
  // software loop: once the divisor exceeds the quotient, no divisor up to
  // the square root has divided the candidate and it is prime.
  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    dsr_nxt       = dsr_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cand_nxt = cand_in;
          dsr_nxt  = DIV_FIRST;
          if (!cand_in[0] || (cand_in == VAL_ONE)) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
          end else begin
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_status.done) begin
          if (dsr_r > div_quo) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (div_rem == '0) begin
            out_valid_nxt = 1'b1;
            out_prime_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            dsr_nxt   = dsr_r + DIV_STEP;
            state_nxt = S_LAUNCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cand_r      <= cand_nxt;
    dsr_r       <= dsr_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer is waiting for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");

  // The divider is never left running while the sequencer is elsewhere.
  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.busy |-> (state_r == S_WAIT))
    else $error("divider busy outside the wait state");

  // Every trial divisor is odd.
  a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> dsr_r[0])
    else $error("even trial divisor");

  // A prime answer can only come from a finished division.
  a_prime_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_prime) |-> $past(div_status.done))
    else $error("prime reported without a completed division");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the trial division prime test
// Sends candidate words under a start/busy handshake and checks every
// one-cycle answer against a trial division predictor kept in the bench. A
// short table of directed words comes first. Random words follow, in phases
// with different amounts of sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // The block under test runs at its default datapath width.
  localparam int WIDTH = tdp_pkg::WIDTH_DEFAULT;
  localparam int CW    = tdp_pkg::CAND_W;

  // Only the low WIDTH bits of a candidate take part in the test.
  localparam logic [CW-1:0] CAND_MASK =
      (WIDTH >= CW) ? {CW{1'b1}} : ((CW'(1) << WIDTH) - CW'(1));

  // Number of random words after the directed table.
  localparam int NUM_RANDOM = 80;

  // Cycle budget. The largest 32-bit prime in the directed table is the slowest
  // word of the run, and the slowest random word is a prime just below 2^24.
  // Sender gaps add little to the run time.
  localparam longint CYCLE_LIMIT = 30_000_000;

  // One expected answer: the candidate is kept for the error message.
  typedef struct {
    logic [CW-1:0] candidate;
    logic          is_prime;
  } answer_t;

  // One row of the directed table. When known is set, the answer is typed
  // into the row. Otherwise the predictor works it out.
  typedef struct {
    logic [CW-1:0] candidate;
    bit            known;
    logic          is_prime;
  } stim_row_t;

  localparam int NUM_DIRECTED = 20;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'd0,          1'b1, 1'b0},  // zero is not prime
    '{32'd1,          1'b1, 1'b0},  // one is not prime
    '{32'd2,          1'b1, 1'b0},  // two is even, so it is rejected
    '{32'd3,          1'b1, 1'b1},  // smallest odd prime, the first divisor already exceeds the quotient
    '{32'd4,          1'b1, 1'b0},
    '{32'd5,          1'b1, 1'b1},
    '{32'd7,          1'b0, 1'b0},
    '{32'd9,          1'b1, 1'b0},  // square of a prime: root must be tried
    '{32'd25,         1'b1, 1'b0},
    '{32'd49,         1'b1, 1'b0},
    '{32'd121,        1'b1, 1'b0},
    '{32'd169,        1'b0, 1'b0},
    '{32'd63001,      1'b1, 1'b0},  // 251 squared
    '{32'd65537,      1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b0, 1'b0},  // all ones
    '{32'hFFFF_FFFE,  1'b1, 1'b0},  // largest even word
    '{32'h8000_0000,  1'b1, 1'b0},  // only the top bit set
    '{32'h8000_0001,  1'b0, 1'b0},
    '{32'd4294967291, 1'b0, 1'b0}   // largest 32-bit prime, the slowest word
  };

  // Divisors that keep large random words fast to reject.
  int small_factors [6] = '{2, 3, 5, 7, 11, 13};

  logic          clk          = 1'b0;
  logic          rst_n        = 1'b0;
  logic          start        = 1'b0;
  logic [CW-1:0] in_candidate = '0;
  logic          busy;
  logic          out_valid;
  logic          out_is_prime;

  // The driver keeps the answer of a typed row here, next to the word it
  // drives, so that the acceptance logic can queue it in place of a
  // predicted one.
  bit   row_known  = 1'b0;
  logic row_answer = 1'b0;

  answer_t pending_answers [$];
  answer_t oldest;
  answer_t fresh;

  int     fail_count      = 0;
  int     words_accepted  = 0;
  int     answers_checked = 0;
  int     primes_seen     = 0;
  longint cycle_count     = 0;

  trial_division_prime_test #(
    .WIDTH(WIDTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_candidate(in_candidate),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  always #10 clk = ~clk;

  // Trial division over the odd divisors up to and including the integer
  // square root. Testing d <= n / d instead of d * d <= n avoids overflow.
  // Even words, zero and one are never prime.
  function automatic logic prime_by_trial(logic [CW-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    n = 64'(cand & CAND_MASK);
    if (n[0] == 1'b0 || n < 3) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // First odd prime at or above a start value. It is used to steer random
  // words toward primes, because primes run the divisor loop to its end.
  function automatic logic [CW-1:0] next_prime_from(logic [CW-1:0] from);
    logic [CW-1:0] n;
    n = (from < 3) ? CW'(3) : (from | CW'(1));
    while (!prime_by_trial(n)) n += 2;
    return n;
  endfunction

  // Length of a sender gap. Each further idle cycle is drawn with the given
  // chance in percent, and the gap is capped.
  function automatic int draw_gap(int pct);
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // Answer checking and acceptance share one clocked block. A result is
  // checked before a new word is queued. An answer always comes later than
  // its word, so this order keeps the queue right.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d answers still pending.",
               cycle_count, pending_answers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_n) begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          $error("out_is_prime: answer %0b arrived with no word pending", out_is_prime);
          fail_count++;
        end else begin
          oldest = pending_answers.pop_front();
          answers_checked++;
          if (out_is_prime !== oldest.is_prime) begin
            $error("out_is_prime for candidate %0d: expected %0b, actual %0b",
                   oldest.candidate, oldest.is_prime, out_is_prime);
            fail_count++;
          end
          if (oldest.is_prime) primes_seen++;
        end
      end
      // A word is taken at an edge where start is high and busy is low.
      if (start && !busy) begin
        fresh.candidate = in_candidate;
        fresh.is_prime  = row_known ? row_answer : prime_by_trial(in_candidate);
        pending_answers.push_back(fresh);
        words_accepted++;
      end
    end
  end

  // Drives one word, starting at a falling edge. During a gap, start is low
  // and the candidate port carries noise that the block must ignore. Then
  // start stays high until the word is taken. The task returns on the
  // falling edge after acceptance, with start still high, so that the next
  // word can follow without a gap.
  task automatic drive_word(logic [CW-1:0] cand, bit known, logic answer, int gap);
    bit taken;
    if (gap > 0) begin
      start        <= 1'b0;
      in_candidate <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_candidate <= cand;
    row_known    <= known;
    row_answer   <= answer;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
  endtask

  initial begin
    int            idle_pct;
    int            size_class;
    int            factor;
    logic [CW-1:0] cand;
    logic [CW-1:0] raw;

    // Synchronous reset, released at a falling edge.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, sent back to back.
    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].candidate, directed_rows[i].known,
                 directed_rows[i].is_prime, 0);
    end

    // Random words in three phases: no idling, a sender that is idle most
    // of the time, and a sender that is idle now and then.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case (i * 3 / NUM_RANDOM)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        default: idle_pct = 14;
      endcase

      // Most words are small, so a prime among them stays cheap. Full-width words
      // get a small factor forced in, so that all upper bits toggle without paying
      // for a 32-bit prime.
      size_class = $urandom_range(99);
      if (size_class < 35) begin
        cand = $urandom_range(65535);
      end else if (size_class < 65) begin
        cand = next_prime_from($urandom_range(3, (1 << 20) - 1));
      end else if (size_class < 75) begin
        cand = next_prime_from($urandom_range(3, 1023));
        cand = cand * cand;
      end else if (size_class < 85) begin
        cand = $urandom_range((1 << 24) - 1);
      end else begin
        raw    = $urandom;
        factor = small_factors[$urandom_range(5)];
        cand   = raw - (raw % factor);
      end

      drive_word(cand, 1'b0, 1'b0, draw_gap(idle_pct));
    end
    start <= 1'b0;

    // Drain. An answer is one cycle wide, so a short tail after the last
    // one is enough to catch a stray extra strobe.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d answers for %0d candidate words, %0d of them prime.",
             answers_checked, words_accepted, primes_seen);
    $display("Covered directed edge words and random words of mixed sizes, %s",
             "back to back and with the sender idling.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
